// ===== rtl/bocf_pkg.sv =====
`default_nettype none
package bocf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int PIX_W  = 8;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;
  localparam int RAD_W  = 3;

  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WINDOW_RADIUS = 2'd2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [PIX_W-1:0] FG_VALUE = 8'd255;
  localparam logic [PIX_W-1:0] BG_VALUE = 8'd0;

  localparam logic [CFG_DW-1:0] RST_FRAME_WIDTH   = 11'd1024;
  localparam logic [CFG_DW-1:0] RST_FRAME_HEIGHT  = 11'd1024;
  localparam logic [RAD_W-1:0]  RST_WINDOW_RADIUS = 3'd1;

  // one raster position moving down the chain
  typedef struct packed {
    logic valid;
    logic sof;
    logic live;
    logic px;
    logic res;
    logic last;
  } slot_t;

endpackage
`default_nettype wire

// ===== rtl/binary_open_close_filter.sv =====
// Binary open-close mask filter: erode, dilate, dilate, erode over a square
// window of side 2r+1, one mask pixel per item in raster order.
// Input stream: tuser selects push (pixel in tdata, nonzero is foreground) or
// drain. Output stream: tdata is 0 or 255, tlast marks the frame's last pixel.
// Configuration writes (width, height, radius) restart the frame; the input
// side holds tready low for one cycle after a write.
// Throughput: one item per cycle unless the receiver stalls. Push i returns
// result i-L, L = 4r(w+1), via the window cells and the output register;
// once the frame is in, each drain returns the next result. If L exceeds the
// frame size the first drain runs L-n internal flush steps with tready low.
// Eight chained window cells, alternating along the row and along the column;
// each column cell keeps a MAX_WIDTH-word column history memory.
// Reset: counters and valid bits clear at once, memories are not cleared and
// the block takes items once init_q is set after reset is released.
// Receiver stall: the whole chain and the input side hold while a result
// waits in the output register.
`default_nettype none
module binary_open_close_filter #(
  parameter int MAX_WIDTH  = bocf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bocf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bocf_pkg::DEF_MAX_RADIUS
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [bocf_pkg::PIX_W-1:0]       s_axis_tdata,  // pixel_in
  input  wire                             s_axis_tuser,  // command
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [bocf_pkg::PIX_W-1:0]      m_axis_tdata,  // pixel_out
  output logic                            m_axis_tlast,
  input  wire                             cfg_we_i,
  input  wire [bocf_pkg::CFG_IW-1:0]      cfg_idx_i,
  input  wire [bocf_pkg::CFG_DW-1:0]      cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);
  localparam int RW = $clog2(MAX_RADIUS+1);
  localparam int NW = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int SW = $clog2(MAX_WIDTH*MAX_HEIGHT + 4*MAX_RADIUS*(MAX_WIDTH+1) + 1);

  logic [bocf_pkg::CFG_DW-1:0] fw_q, fh_q;
  logic [bocf_pkg::RAD_W-1:0]  rad_q;
  logic [CW-1:0] w_c, w_q;
  logic [HW-1:0] h_c, h_q;
  logic [RW-1:0] r_c, r_q;
  logic [NW-1:0] n_q, res_cnt_q;
  logic [SW-1:0] lat_q, sidx_q;
  logic          init_q, flush_q;
  logic          out_valid_q, out_last_q;
  logic [bocf_pkg::PIX_W-1:0] out_px_q;

  logic en, acc_in, is_push, all_in, pending, is_res, res_last, issue;
  bocf_pkg::slot_t chain [9];

  always_comb begin
    if (fw_q == '0)                    w_c = CW'(1);
    else if (int'(fw_q) > MAX_WIDTH)   w_c = CW'(MAX_WIDTH);
    else                               w_c = CW'(fw_q);
    if (fh_q == '0)                    h_c = HW'(1);
    else if (int'(fh_q) > MAX_HEIGHT)  h_c = HW'(MAX_HEIGHT);
    else                               h_c = HW'(fh_q);
    if (int'(rad_q) > MAX_RADIUS)      r_c = RW'(MAX_RADIUS);
    else                               r_c = RW'(rad_q);
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_c;
    h_q   <= h_c;
    r_q   <= r_c;
    n_q   <= NW'(NW'(w_c) * NW'(h_c));
    lat_q <= SW'((SW'(r_c) * SW'(w_c) + SW'(r_c)) << 2);
  end

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en && init_q && !flush_q;
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign is_push       = (s_axis_tuser == bocf_pkg::CMD_PUSH);
  assign all_in        = (sidx_q >= SW'(n_q));
  assign pending       = (res_cnt_q < n_q);
  assign is_res        = (sidx_q >= lat_q);
  assign res_last      = is_res && (res_cnt_q == n_q - NW'(1));
  assign issue         = en && init_q &&
                         (flush_q || (acc_in && (is_push ? !all_in : (all_in && pending))));

  assign chain[0] = '{valid: issue, sof: (sidx_q == '0), live: 1'b1,
                      px: is_push && (s_axis_tdata != '0), res: is_res, last: res_last};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= bocf_pkg::RST_FRAME_WIDTH;
      fh_q      <= bocf_pkg::RST_FRAME_HEIGHT;
      rad_q     <= bocf_pkg::RST_WINDOW_RADIUS;
      sidx_q    <= '0;
      res_cnt_q <= '0;
      flush_q   <= 1'b0;
      init_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bocf_pkg::CFG_FRAME_WIDTH: begin
          fw_q      <= cfg_data_i;
          sidx_q    <= '0;
          res_cnt_q <= '0;
          flush_q   <= 1'b0;
          init_q    <= 1'b0;
        end
        bocf_pkg::CFG_FRAME_HEIGHT: begin
          fh_q      <= cfg_data_i;
          sidx_q    <= '0;
          res_cnt_q <= '0;
          flush_q   <= 1'b0;
          init_q    <= 1'b0;
        end
        bocf_pkg::CFG_WINDOW_RADIUS: begin
          rad_q     <= cfg_data_i[bocf_pkg::RAD_W-1:0];
          sidx_q    <= '0;
          res_cnt_q <= '0;
          flush_q   <= 1'b0;
          init_q    <= 1'b0;
        end
        default: begin
          init_q <= 1'b0;
        end
      endcase
    end else begin
      init_q <= 1'b1;
      if (issue) begin
        if (res_last) begin
          sidx_q    <= '0;
          res_cnt_q <= '0;
          flush_q   <= 1'b0;
        end else begin
          sidx_q    <= sidx_q + SW'(1);
          res_cnt_q <= res_cnt_q + NW'(is_res);
          if (flush_q || !is_push) flush_q <= !is_res;
        end
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_pair
    localparam logic ER = (g == 0) || (g == 3);
    bocf_hcell #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_RADIUS(MAX_RADIUS),
      .ERODE     (ER)
    ) u_hcell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .w_i   (w_q),
      .r_i   (r_q),
      .slot_i(chain[2*g]),
      .slot_o(chain[2*g+1])
    );
    bocf_vcell #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT),
      .MAX_RADIUS(MAX_RADIUS),
      .ERODE     (ER)
    ) u_vcell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .w_i   (w_q),
      .h_i   (h_q),
      .r_i   (r_q),
      .slot_i(chain[2*g+1]),
      .slot_o(chain[2*g+2])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[8].valid && chain[8].res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_px_q   <= chain[8].px ? bocf_pkg::FG_VALUE : bocf_pkg::BG_VALUE;
      out_last_q <= chain[8].last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_px_q;
  assign m_axis_tlast  = out_last_q;

endmodule
`default_nettype wire

// ===== rtl/bocf_hcell.sv =====
`default_nettype none
module bocf_hcell #(
  parameter int   MAX_WIDTH  = bocf_pkg::DEF_MAX_WIDTH,
  parameter int   MAX_RADIUS = bocf_pkg::DEF_MAX_RADIUS,
  parameter logic ERODE      = 1'b1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire [$clog2(MAX_WIDTH+1)-1:0]    w_i,
  input  wire [$clog2(MAX_RADIUS+1)-1:0]   r_i,
  input  wire bocf_pkg::slot_t             slot_i,
  output bocf_pkg::slot_t                  slot_o
);

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_RADIUS+1);
  localparam int HB = 2*MAX_RADIUS;

  logic [HB-1:0] win_q;
  logic [XW-1:0] x_q, x_b, x_d;
  logic [RW-1:0] warm_q, warm_b, warm_d;
  logic [HB:0]   vec;
  logic          out_live;
  logic          acc;
  bocf_pkg::slot_t slot_q;

  always_comb begin
    int col;
    x_b      = slot_i.sof ? '0 : x_q;
    warm_b   = slot_i.sof ? '0 : warm_q;
    vec      = {win_q, slot_i.px};
    out_live = slot_i.live && (warm_b >= r_i);
    acc      = ERODE;
    for (int k = 0; k <= HB; k++) begin
      col = int'(x_b) + int'(r_i) - k;
      if (k <= 2*int'(r_i) && col >= 0 && col <= int'(w_i) - 1) begin
        if (ERODE) acc = acc & vec[k];
        else       acc = acc | vec[k];
      end
    end
    warm_d = (slot_i.live && warm_b < r_i) ? warm_b + RW'(1) : warm_b;
    if (out_live) x_d = (CW'(x_b) + CW'(1) == w_i) ? '0 : x_b + XW'(1);
    else          x_d = x_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      warm_q <= '0;
      slot_q <= '0;
    end else if (en_i) begin
      if (slot_i.valid) begin
        x_q    <= x_d;
        warm_q <= warm_d;
      end
      slot_q <= '{valid: slot_i.valid, sof: slot_i.sof, live: out_live, px: acc,
                  res: slot_i.res, last: slot_i.last};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && slot_i.valid && slot_i.live) begin
      win_q <= vec[HB-1:0];
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== rtl/bocf_vcell.sv =====
`default_nettype none
module bocf_vcell #(
  parameter int   MAX_WIDTH  = bocf_pkg::DEF_MAX_WIDTH,
  parameter int   MAX_HEIGHT = bocf_pkg::DEF_MAX_HEIGHT,
  parameter int   MAX_RADIUS = bocf_pkg::DEF_MAX_RADIUS,
  parameter logic ERODE      = 1'b1
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              en_i,
  input  wire [$clog2(MAX_WIDTH+1)-1:0]    w_i,
  input  wire [$clog2(MAX_HEIGHT+1)-1:0]   h_i,
  input  wire [$clog2(MAX_RADIUS+1)-1:0]   r_i,
  input  wire bocf_pkg::slot_t             slot_i,
  output bocf_pkg::slot_t                  slot_o
);

  localparam int CW = $clog2(MAX_WIDTH+1);
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = $clog2(MAX_HEIGHT + 8*MAX_RADIUS + 4);
  localparam int HB = 2*MAX_RADIUS;

  // per column: the last 2*MAX_RADIUS rows, newest in bit 0
  logic [HB-1:0] mem [MAX_WIDTH];
  logic [HB-1:0] rd_q;
  logic [XW-1:0] xi_q, x_b, x_n;
  logic [YW-1:0] yi_q, y_b, y_n;
  logic [HB:0]   vec;
  logic          wrap;
  logic          out_live;
  logic          acc;
  bocf_pkg::slot_t slot_q;

  always_comb begin
    x_b      = slot_i.sof ? '0 : xi_q;
    y_b      = slot_i.sof ? '0 : yi_q;
    vec      = {rd_q, slot_i.px};
    out_live = slot_i.live && (y_b >= YW'(r_i));
    acc      = ERODE;
    for (int k = 0; k <= HB; k++) begin
      if (k <= 2*int'(r_i) && k <= int'(y_b) && int'(y_b) - k <= int'(h_i) - 1) begin
        if (ERODE) acc = acc & vec[k];
        else       acc = acc | vec[k];
      end
    end
    wrap = (CW'(x_b) + CW'(1) == w_i);
    x_n  = wrap ? '0 : x_b + XW'(1);
    y_n  = wrap ? y_b + YW'(1) : y_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xi_q   <= '0;
      yi_q   <= '0;
      slot_q <= '0;
    end else if (en_i) begin
      if (slot_i.valid) begin
        xi_q <= slot_i.live ? x_n : x_b;
        yi_q <= slot_i.live ? y_n : y_b;
      end
      slot_q <= '{valid: slot_i.valid, sof: slot_i.sof, live: out_live, px: acc,
                  res: slot_i.res, last: slot_i.last};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && slot_i.valid && slot_i.live) begin
      mem[x_b] <= vec[HB-1:0];
      rd_q     <= (x_n == x_b) ? vec[HB-1:0] : mem[x_n];
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== rtl/bocf_checker.sv =====
`default_nettype none
module bocf_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        s_axis_tvalid,
  input wire                        s_axis_tready,
  input wire                        m_axis_tvalid,
  input wire                        m_axis_tready,
  input wire [bocf_pkg::PIX_W-1:0]  m_axis_tdata,
  input wire                        m_axis_tlast,
  input wire                        cfg_we_i
);

  // results are binary
  a_binary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata == bocf_pkg::FG_VALUE ||
                       m_axis_tdata == bocf_pkg::BG_VALUE))
    else $error("result not binary");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // input side waits while a result is stuck
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken during output stall");

  a_cfg_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input ready right after config write");

endmodule

bind binary_open_close_filter bocf_checker u_bocf_checker (.*);
`default_nettype wire

// ===== test/tb_binary_open_close_filter.sv =====
`timescale 1ns / 1ps
module tb_binary_open_close_filter;

  localparam int MAXN = bocf_pkg::DEF_MAX_WIDTH * bocf_pkg::DEF_MAX_HEIGHT;
  localparam int ITEMS = 1450;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PW = bocf_pkg::PIX_W;
  localparam int DW = bocf_pkg::CFG_DW;

  typedef enum logic [1:0] {ROW_CFG, ROW_PUSH, ROW_DRAIN} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [bocf_pkg::CFG_IW-1:0] idx;
    logic [bocf_pkg::CFG_DW-1:0] val;
    bit                          typed;
    logic [bocf_pkg::PIX_W-1:0]  exp_px;
    logic                        exp_last;
  } row_t;

  typedef struct {
    logic [bocf_pkg::PIX_W-1:0] px;
    logic                       last;
  } mask_result_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [bocf_pkg::PIX_W-1:0] s_axis_tdata;  // pixel_in
  logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [bocf_pkg::PIX_W-1:0] m_axis_tdata;  // pixel_out
  logic cfg_we_i;
  logic [bocf_pkg::CFG_IW-1:0] cfg_idx_i;
  logic [bocf_pkg::CFG_DW-1:0] cfg_data_i;

  binary_open_close_filter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // shadow registers and frame counters
  logic [bocf_pkg::CFG_DW-1:0] width_reg, height_reg;
  logic [bocf_pkg::RAD_W-1:0]  radius_reg;
  int unsigned pushed_cnt, out_idx;
  bit frame_px [MAXN];
  bit filt_px [MAXN];
  bit work_a [MAXN];
  bit work_b [MAXN];
  bit filt_stale;

  mask_result_t result_q[$];
  bit use_typed;
  mask_result_t typed_res;

  int errors, cycles, checked, frames, sent;
  int send_gap_pct, recv_gap_pct;

  function automatic int unsigned eff_w();
    return width_reg == 0 ? 1 : (width_reg > bocf_pkg::DEF_MAX_WIDTH ?
                                 bocf_pkg::DEF_MAX_WIDTH : width_reg);
  endfunction
  function automatic int unsigned eff_h();
    return height_reg == 0 ? 1 : (height_reg > bocf_pkg::DEF_MAX_HEIGHT ?
                                  bocf_pkg::DEF_MAX_HEIGHT : height_reg);
  endfunction
  function automatic int unsigned eff_r();
    return radius_reg > bocf_pkg::DEF_MAX_RADIUS ? bocf_pkg::DEF_MAX_RADIUS : radius_reg;
  endfunction

  // erode, erode, dilate, dilate, dilate, dilate, erode, erode; odd passes along the row
  task automatic refilter();
    int unsigned w, h, r, n, x, y, c, lim, lo, hi, idx;
    bit erode, odd, v;
    w = eff_w(); h = eff_h(); r = eff_r(); n = w * h;
    for (int j = 0; j < n; j++) work_a[j] = frame_px[j];
    for (int q = 1; q <= 8; q++) begin
      erode = (q <= 2) || (q >= 7);
      odd = (q % 2) != 0;
      for (int j = 0; j < n; j++) begin
        y = j / w; x = j % w;
        c = odd ? x : y;
        lim = odd ? w : h;
        lo = c >= r ? c - r : 0;
        hi = c + r < lim - 1 ? c + r : lim - 1;
        v = erode;
        for (int t = lo; t <= hi; t++) begin
          idx = odd ? y * w + t : t * w + x;
          if (erode && !work_a[idx]) v = 0;
          if (!erode && work_a[idx]) v = 1;
        end
        work_b[j] = v;
      end
      for (int j = 0; j < n; j++) work_a[j] = work_b[j];
    end
    for (int j = 0; j < n; j++) filt_px[j] = work_a[j];
    filt_stale = 0;
  endtask

  task automatic emit_result();
    mask_result_t res;
    int unsigned n;
    n = eff_w() * eff_h();
    if (filt_stale) refilter();
    res.px = filt_px[out_idx] ? bocf_pkg::FG_VALUE : bocf_pkg::BG_VALUE;
    res.last = out_idx == n - 1;
    if (use_typed) res = typed_res;
    result_q.push_back(res);
    out_idx++;
    if (out_idx >= n) begin
      out_idx = 0;
      pushed_cnt = 0;
    end
  endtask

  task automatic predict_item(logic cmd, logic [bocf_pkg::PIX_W-1:0] px);
    int unsigned n, lat;
    bit fg;
    n = eff_w() * eff_h();
    lat = 4 * eff_r() * (eff_w() + 1);
    if (cmd == bocf_pkg::CMD_PUSH) begin
      if (pushed_cnt >= n) return;
      fg = px != 0;
      if (frame_px[pushed_cnt] != fg) filt_stale = 1;
      frame_px[pushed_cnt] = fg;
      pushed_cnt++;
      if (pushed_cnt - 1 >= lat) emit_result();
    end else if (pushed_cnt >= n && out_idx < n) begin
      emit_result();
    end
  endtask

  task automatic report(string what, mask_result_t got, mask_result_t want);
    $display("mismatch %s: got px=%0d last=%0b, want px=%0d last=%0b",
             what, got.px, got.last, want.px, want.last);
    errors++;
  endtask

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // input side and configuration monitor
  always @(posedge clk_i) begin
    bit restart;
    restart = 0;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        bocf_pkg::CFG_FRAME_WIDTH: begin
          width_reg = cfg_data_i;
          restart = 1;
        end
        bocf_pkg::CFG_FRAME_HEIGHT: begin
          height_reg = cfg_data_i;
          restart = 1;
        end
        bocf_pkg::CFG_WINDOW_RADIUS: begin
          radius_reg = cfg_data_i[bocf_pkg::RAD_W-1:0];
          restart = 1;
        end
        default: restart = 0;
      endcase
      if (restart) begin
        pushed_cnt = 0;
        out_idx = 0;
        filt_stale = 1;
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
  end

  // output side
  always @(posedge clk_i) begin
    mask_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.px = m_axis_tdata;
      got.last = m_axis_tlast;
      if (result_q.size() == 0) begin
        report("unexpected item", got, got);
      end else begin
        want = result_q.pop_front();
        checked++;
        if (got.px !== want.px) report("pixel_out", got, want);
        else if (got.last !== want.last) report("frame_last", got, want);
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= $urandom_range(0, 99) >= recv_gap_pct;
  end

  task automatic send(logic cmd, logic [bocf_pkg::PIX_W-1:0] px);
    @(negedge clk_i);
    if (sent < ITEMS / 3) begin
      send_gap_pct = 38; recv_gap_pct = 51;
    end else if (sent < 2 * ITEMS / 3) begin
      send_gap_pct = 51; recv_gap_pct = 38;
    end else begin
      send_gap_pct = 0; recv_gap_pct = 0;
    end
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid = 0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tuser = cmd;
    s_axis_tdata = px;
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
  endtask

  task automatic cfg_write(logic [bocf_pkg::CFG_IW-1:0] idx, logic [bocf_pkg::CFG_DW-1:0] val);
    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  task automatic run_frame();
    int unsigned w, h, r, n, lat, drains, stop_at, fg_pct, pick, ew, eh, cost;
    pick = $urandom_range(0, 19);
    case (pick)
      0: begin w = 0; h = $urandom_range(0, 2); r = $urandom_range(0, 7); end
      1: begin w = 2047; h = 1; r = 0; end
      2: begin w = 1; h = 2047; r = $urandom_range(0, 2); end
      3: begin w = $urandom_range(1, 6); h = $urandom_range(1, 6); r = 7; end
      4: begin w = $urandom_range(20, 40); h = $urandom_range(8, 16); r = $urandom_range(0, 4); end
      default: begin
        w = $urandom_range(1, 12); h = $urandom_range(1, 12); r = $urandom_range(0, 3);
      end
    endcase
    // keep the item count near the budget
    ew = w == 0 ? 1 : (w > bocf_pkg::DEF_MAX_WIDTH ? bocf_pkg::DEF_MAX_WIDTH : w);
    eh = h == 0 ? 1 : (h > bocf_pkg::DEF_MAX_HEIGHT ? bocf_pkg::DEF_MAX_HEIGHT : h);
    cost = ew * eh + (ew * eh < 4 * r * (ew + 1) ? ew * eh : 4 * r * (ew + 1));
    if (sent + cost > ITEMS + 60) begin
      w = 2; h = 2; r = $urandom_range(0, 3);
    end
    cfg_write(bocf_pkg::CFG_FRAME_WIDTH, DW'(w));
    cfg_write(bocf_pkg::CFG_FRAME_HEIGHT, DW'(h));
    cfg_write(bocf_pkg::CFG_WINDOW_RADIUS, DW'(r));
    @(negedge clk_i);
    n = eff_w() * eff_h();
    lat = 4 * eff_r() * (eff_w() + 1);
    fg_pct = $urandom_range(30, 95);
    for (int j = 0; j < n; j++) frame_px[j] = $urandom_range(0, 99) < fg_pct;
    filt_stale = 1;
    // a broken frame is cut short and then abandoned by the next write
    stop_at = $urandom_range(0, 9) == 0 ? $urandom_range(0, n - 1) : n;
    for (int j = 0; j < stop_at; j++) begin
      if ($urandom_range(0, 99) < 4) send(bocf_pkg::CMD_DRAIN, PW'($urandom_range(0, 255)));
      send(bocf_pkg::CMD_PUSH, frame_px[j] ? PW'($urandom_range(1, 255)) : PW'(0));
      sent++;
    end
    if (stop_at == n) begin
      drains = n < lat ? n : lat;
      for (int j = 0; j < drains; j++) begin
        if (j + 1 < drains && $urandom_range(0, 99) < 4) send(bocf_pkg::CMD_PUSH, 8'hff);
        send(bocf_pkg::CMD_DRAIN, PW'($urandom_range(0, 255)));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) send(bocf_pkg::CMD_DRAIN, 0);
    end
    frames++;
  endtask

  row_t rows[$];

  initial begin
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tuser = bocf_pkg::CMD_PUSH;
    s_axis_tdata = 0;
    m_axis_tready = 0;
    cfg_we_i = 0;
    cfg_idx_i = bocf_pkg::CFG_FRAME_WIDTH;
    cfg_data_i = 0;
    width_reg = bocf_pkg::RST_FRAME_WIDTH;
    height_reg = bocf_pkg::RST_FRAME_HEIGHT;
    radius_reg = bocf_pkg::RST_WINDOW_RADIUS;
    filt_stale = 1;
    send_gap_pct = 38;
    recv_gap_pct = 51;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // single pixel frame then a 3x2 frame, radius zero: the result is the binarized input
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_WINDOW_RADIUS, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_FRAME_WIDTH, 1, 0, 0, 0});
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_FRAME_HEIGHT, 1, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h00, 1, bocf_pkg::BG_VALUE, 1});
    rows.push_back('{ROW_PUSH, 0, 8'h01, 1, bocf_pkg::FG_VALUE, 1});
    rows.push_back('{ROW_PUSH, 0, 8'h80, 1, bocf_pkg::FG_VALUE, 1});
    rows.push_back('{ROW_PUSH, 0, 8'hff, 1, bocf_pkg::FG_VALUE, 1});
    rows.push_back('{ROW_DRAIN, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_FRAME_WIDTH, 3, 0, 0, 0});
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_FRAME_HEIGHT, 2, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h55, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'haa, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h00, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h02, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h04, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h00, 0, 0, 0});
    // latency longer than the frame: every result comes from drains
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_WINDOW_RADIUS, 1, 0, 0, 0});
    rows.push_back('{ROW_CFG, bocf_pkg::CFG_FRAME_WIDTH, 2, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'hff, 0, 0, 0});
    rows.push_back('{ROW_DRAIN, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h10, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h20, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h00, 0, 0, 0});
    rows.push_back('{ROW_PUSH, 0, 8'h40, 0, 0, 0});
    for (int i = 0; i < 5; i++) rows.push_back('{ROW_DRAIN, 0, 0, 0, 0, 0});

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        cfg_write(rows[i].idx, rows[i].val);
      end else begin
        use_typed = rows[i].typed;
        typed_res.px = rows[i].exp_px;
        typed_res.last = rows[i].exp_last;
        send(rows[i].kind == ROW_DRAIN ? bocf_pkg::CMD_DRAIN : bocf_pkg::CMD_PUSH,
             rows[i].val[bocf_pkg::PIX_W-1:0]);
        @(negedge clk_i);
        s_axis_tvalid = 0;
        use_typed = 0;
      end
    end

    while (sent < ITEMS) begin
      run_frame();
    end

    @(negedge clk_i);
    s_axis_tvalid = 0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("%0d frames, %0d items sent, %0d results checked, %0d mismatches",
             frames, sent, checked, errors);
    $display("sizes down to one pixel and clamped up to 1024, radius 0 to 7, drains and aborts");
    if (errors == 0 && result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bocf_pkg.sv
rtl/bocf_hcell.sv
rtl/bocf_vcell.sv
rtl/binary_open_close_filter.sv
rtl/bocf_checker.sv
test/tb_binary_open_close_filter.sv
